### rtl/dntp_pkg.sv
// Shared types, codes and constants of the decimal text parser.
// No dependencies; every other file of the parser imports this package.
`default_nettype none

package dntp_pkg;

	// Width of the digit accumulator; fifteen digits and a K suffix stay below 2^60.
	localparam int ACC_W = 60;

	// Rounded division unit widths: numerator is magnitude plus half the divisor.
	localparam int NUM_W = ACC_W + 1;
	localparam int DEN_W = 50;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_END   = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// Characters of the grammar.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_KILO  = 8'h4B;

	// One finished string handed from the parser front to the scaling back end.
	typedef struct packed {
		logic [1:0]       kind;  // ST_OK for a number, else ST_EMPTY or ST_END
		logic             neg;
		logic [ACC_W-1:0] mag;
		logic [3:0]       dp;    // fraction digits seen
		logic [2:0]       tp;    // target decimal places
	} job_t;

	// Powers of ten used as rounding divisors.
	function automatic logic [DEN_W-1:0] pow10(input logic [3:0] k);
		logic [DEN_W-1:0] p;
		unique case (k)
			4'd0:    p = 50'd1;
			4'd1:    p = 50'd10;
			4'd2:    p = 50'd100;
			4'd3:    p = 50'd1000;
			4'd4:    p = 50'd10000;
			4'd5:    p = 50'd100000;
			4'd6:    p = 50'd1000000;
			4'd7:    p = 50'd10000000;
			4'd8:    p = 50'd100000000;
			4'd9:    p = 50'd1000000000;
			4'd10:   p = 50'd10000000000;
			4'd11:   p = 50'd100000000000;
			4'd12:   p = 50'd1000000000000;
			4'd13:   p = 50'd10000000000000;
			4'd14:   p = 50'd100000000000000;
			default: p = 50'd1000000000000000;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

### rtl/dntp_front.sv
// Character parser front end: runs the grammar one byte per cycle while the queue is not full.
// Depends on dntp_pkg; pushes one job per terminator into dntp_fifo.
`default_nettype none

module dntp_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [7:0]       ch,
	input  wire logic [3:0]       digit_budget,
	input  wire logic [3:0]       fraction_limit,
	input  wire logic [2:0]       target_places,
	input  wire logic             full,
	output logic                  push,
	output dntp_pkg::job_t        job
);
	import dntp_pkg::*;

	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_INT    = 3'd1;
	localparam logic [2:0] PH_FRAC   = 3'd2;
	localparam logic [2:0] PH_SUFFIX = 3'd3;
	localparam logic [2:0] PH_ERROR  = 3'd4;

	logic [2:0]       phase_q, phase_n;
	logic             neg_q, neg_n;
	logic [ACC_W-1:0] acc_q, acc_n;
	logic [3:0]       icnt_q, icnt_n;
	logic [3:0]       fcnt_q, fcnt_n;

	logic             accept;
	logic             digit_ch;
	logic [3:0]       dval;
	logic [ACC_W-1:0] acc_x10;
	logic [ACC_W-1:0] acc_x1000;
	logic [3:0]       room;
	logic [3:0]       allow;
	logic [2:0]       eff_phase;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	// Digit decode and the two accumulator updates, built from shifts, adds and subtracts.
	always_comb begin
		digit_ch  = (ch >= CH_ZERO) && (ch <= CH_NINE);
		dval      = 4'(ch - CH_ZERO);
		acc_x10   = (acc_q << 3) + (acc_q << 1) + ACC_W'(dval);
		acc_x1000 = (acc_q << 10) - (acc_q << 4) - (acc_q << 3);
		room      = (icnt_q < digit_budget) ? (digit_budget - icnt_q) : 4'd0;
		allow     = (room < fraction_limit) ? room : fraction_limit;
	end

	// Grammar step for one non-terminator byte.
	always_comb begin
		phase_n   = phase_q;
		neg_n     = neg_q;
		acc_n     = acc_q;
		icnt_n    = icnt_q;
		fcnt_n    = fcnt_q;
		eff_phase = (phase_q == PH_START) ? PH_INT : phase_q;
		if ((phase_q == PH_START) && (ch == CH_MINUS)) begin
			neg_n   = 1'b1;
			phase_n = PH_INT;
		end else begin
			unique case (eff_phase)
				PH_INT: begin
					if (digit_ch && (icnt_q < digit_budget)) begin
						acc_n   = acc_x10;
						icnt_n  = icnt_q + 4'd1;
						phase_n = PH_INT;
					end else if ((ch == CH_POINT) && (fraction_limit != 4'd0)) begin
						phase_n = PH_FRAC;
					end else if (ch == CH_KILO) begin
						acc_n   = acc_x1000;
						phase_n = PH_SUFFIX;
					end else begin
						phase_n = PH_ERROR;
					end
				end
				PH_FRAC: begin
					if (digit_ch && (fcnt_q < allow)) begin
						acc_n  = acc_x10;
						fcnt_n = fcnt_q + 4'd1;
					end else if (ch == CH_KILO) begin
						acc_n   = acc_x1000;
						phase_n = PH_SUFFIX;
					end else begin
						phase_n = PH_ERROR;
					end
				end
				default: phase_n = PH_ERROR;
			endcase
		end
	end

	// Job handed to the back end on the terminator.
	always_comb begin
		push     = accept && (ch == CH_NUL);
		job.neg  = neg_q;
		job.mag  = acc_q;
		job.dp   = fcnt_q;
		job.tp   = target_places;
		if (phase_q == PH_START) begin
			job.kind = ST_EMPTY;
		end else if (phase_q == PH_ERROR) begin
			job.kind = ST_END;
		end else begin
			job.kind = ST_OK;
		end
	end

	// Parser state; a terminator returns it to the start of a string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			icnt_q  <= '0;
			fcnt_q  <= '0;
		end else if (accept) begin
			if (ch == CH_NUL) begin
				phase_q <= PH_START;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				icnt_q  <= '0;
				fcnt_q  <= '0;
			end else begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				acc_q   <= acc_n;
				icnt_q  <= icnt_n;
				fcnt_q  <= fcnt_n;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/dntp_fifo.sv
// Two-entry job queue between the parser front and the scaling back end.
// Depends on dntp_pkg for the job type.
`default_nettype none

module dntp_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  dntp_pkg::job_t      din,
	output logic                full,
	input  wire logic           pop,
	output dntp_pkg::job_t      dout,
	output logic                not_empty
);
	import dntp_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	job_t               entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;

	assign full      = (count_q == (PTR_W + 1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign dout      = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/dntp_div.sv
// Restoring divider, one quotient bit per cycle, for the rounded rescale.
// Depends on dntp_pkg for the operand widths.
`default_nettype none

module dntp_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [dntp_pkg::NUM_W-1:0]   num,
	input  wire logic [dntp_pkg::DEN_W-1:0]   den,
	output logic                              done,
	output logic [dntp_pkg::NUM_W-1:0]        quot
);
	import dntp_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             qbit;

	assign done = done_q;
	assign quot = num_q;

	// One trial subtraction per cycle.
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		qbit  = (trial >= {1'b0, den_q});
	end

	// Datapath registers shift the quotient in behind the numerator bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= qbit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], qbit};
		end
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

### rtl/dntp_back.sv
// Scaling back end: rescale, saturate, sign, range check and result register.
// Depends on dntp_pkg and instantiates dntp_div.
`default_nettype none

module dntp_back #(
	parameter int CAP_BITS = 60
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          job_valid,
	input  dntp_pkg::job_t                     job,
	output logic                               pop,
	input  wire logic signed [60:0]            lower_limit,
	input  wire logic signed [60:0]            upper_limit,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [1:0]                         out_status,
	output logic signed [60:0]                 out_value,
	output logic [2:0]                         out_places
);
	import dntp_pkg::*;

	localparam logic [ACC_W-1:0] CAP = {ACC_W{1'b1}} >> (ACC_W - CAP_BITS);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_MUL  = 3'd1;
	localparam logic [2:0] B_DIV  = 3'd2;
	localparam logic [2:0] B_CAP  = 3'd3;
	localparam logic [2:0] B_OUT  = 3'd4;

	logic [2:0]          state_q;
	logic                neg_q;
	logic [ACC_W-1:0]    mag_q;
	logic [2:0]          cnt_q;
	logic                sat_q;
	logic [2:0]          tp_q;
	logic [1:0]          status_q;
	logic signed [60:0]  val_q;

	logic                out_valid_q;
	logic [1:0]          out_status_q;
	logic signed [60:0]  out_value_q;
	logic [2:0]          out_places_q;

	logic                div_start;
	logic [NUM_W-1:0]    div_num;
	logic [DEN_W-1:0]    div_den;
	logic                div_done;
	logic [NUM_W-1:0]    div_quot;

	logic [ACC_W+3:0]    prod;
	logic                over_cap;
	logic [ACC_W-1:0]    capped;
	logic                out_free;
	logic                limits_ok;
	logic [3:0]          down_k;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_value  = out_value_q;
	assign out_places = out_places_q;

	// Operand preparation: one multiply-by-ten step, rounding divisor, cap test.
	always_comb begin
		prod      = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1);
		over_cap  = (mag_q > CAP);
		capped    = over_cap ? CAP : mag_q;
		down_k    = job.dp - {1'b0, job.tp};
		div_den   = pow10(down_k);
		div_num   = {1'b0, job.mag} + NUM_W'(div_den >> 1);
		out_free  = !out_valid_q || out_ready;
		limits_ok = (val_q >= lower_limit) && (val_q <= upper_limit);
		pop       = (state_q == B_IDLE) && job_valid;
		div_start = pop && (job.kind == ST_OK) && (job.dp > {1'b0, job.tp});
	end

	dntp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Sequencer for one job at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						if (job.kind != ST_OK) begin
							state_q <= B_OUT;
						end else if ({1'b0, job.tp} > job.dp) begin
							state_q <= B_MUL;
						end else if (job.dp > {1'b0, job.tp}) begin
							state_q <= B_DIV;
						end else begin
							state_q <= B_CAP;
						end
					end
				end
				B_MUL: begin
					if ((prod > {4'b0, CAP}) || (cnt_q == 3'd1)) begin
						state_q <= B_CAP;
					end
				end
				B_DIV: begin
					if (div_done) begin
						state_q <= B_CAP;
					end
				end
				B_CAP: state_q <= B_OUT;
				B_OUT: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Working registers of the job in flight.
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					neg_q    <= job.neg;
					mag_q    <= job.mag;
					tp_q     <= job.tp;
					sat_q    <= 1'b0;
					status_q <= job.kind;
					val_q    <= '0;
					cnt_q    <= 3'(job.tp - job.dp[2:0]);
				end
			end
			B_MUL: begin
				if (prod > {4'b0, CAP}) begin
					mag_q <= CAP;
					sat_q <= 1'b1;
				end else begin
					mag_q <= prod[ACC_W-1:0];
					cnt_q <= cnt_q - 3'd1;
				end
			end
			B_DIV: begin
				if (div_done) begin
					mag_q <= div_quot[ACC_W-1:0];
				end
			end
			B_CAP: begin
				sat_q <= sat_q || over_cap;
				val_q <= neg_q ? -$signed({1'b0, capped}) : $signed({1'b0, capped});
			end
			default: begin
			end
		endcase
	end

	// Result register; it holds until the downstream side takes the transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == B_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == B_OUT) && out_free) begin
			out_value_q  <= val_q;
			out_places_q <= tp_q;
			if ((status_q == ST_OK) && (sat_q || !limits_ok)) begin
				out_status_q <= ST_RANGE;
			end else begin
				out_status_q <= status_q;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/decimal_number_text_parser.sv
// Decimal text parser top level: configuration registers, front, queue, back end.
// Depends on dntp_pkg, dntp_front, dntp_fifo and dntp_back.
//
// The parser takes one character per cycle on the slave stream; characters stall
// only while the two-entry job queue is full. Each terminator yields one result,
// registered on the master stream. A result whose status is empty or end expected
// skips the rescale; a number that needs no rescale goes straight to the cap stage,
// one that is scaled up takes at most seven steps of ten, and one whose fraction
// digits must be rounded away passes through the 61-step restoring divider.
// Configuration is taken through cfg_we, cfg_index and cfg_data; the user must
// write it only while idle, which the block itself does not enforce.
`default_nettype none

module decimal_number_text_parser #(
	parameter int VALUE_BITS = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Input stream; tdata: [7:0] ch.
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,
	// Result stream; tdata: [1:0] status, [62:2] value, [65:63] places, [71:66] zero.
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [71:0]       m_axis_tdata,
	// Configuration write port.
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [60:0]  cfg_data
);
	import dntp_pkg::*;

	localparam int CAP_BITS = (VALUE_BITS - 1 < ACC_W) ? VALUE_BITS - 1 : ACC_W;

	localparam logic [2:0] REG_DIGIT_BUDGET   = 3'd0;
	localparam logic [2:0] REG_FRACTION_LIMIT = 3'd1;
	localparam logic [2:0] REG_TARGET_PLACES  = 3'd2;
	localparam logic [2:0] REG_LOWER_LIMIT    = 3'd3;
	localparam logic [2:0] REG_UPPER_LIMIT    = 3'd4;

	logic [3:0]         digit_budget_q;
	logic [3:0]         fraction_limit_q;
	logic [2:0]         target_places_q;
	logic signed [60:0] lower_limit_q;
	logic signed [60:0] upper_limit_q;

	logic               push;
	logic               full;
	logic               pop;
	logic               job_valid;
	job_t               front_job;
	job_t               back_job;
	logic [1:0]         res_status;
	logic signed [60:0] res_value;
	logic [2:0]         res_places;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_budget_q   <= 4'd9;
			fraction_limit_q <= 4'd0;
			target_places_q  <= 3'd0;
			lower_limit_q    <= '0;
			upper_limit_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIGIT_BUDGET:   digit_budget_q   <= cfg_data[3:0];
				REG_FRACTION_LIMIT: fraction_limit_q <= cfg_data[3:0];
				REG_TARGET_PLACES:  target_places_q  <= cfg_data[2:0];
				REG_LOWER_LIMIT:    lower_limit_q    <= cfg_data;
				REG_UPPER_LIMIT:    upper_limit_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	dntp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.ch             (s_axis_tdata),
		.digit_budget   (digit_budget_q),
		.fraction_limit (fraction_limit_q),
		.target_places  (target_places_q),
		.full           (full),
		.push           (push),
		.job            (front_job)
	);

	dntp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (front_job),
		.full      (full),
		.pop       (pop),
		.dout      (back_job),
		.not_empty (job_valid)
	);

	dntp_back #(
		.CAP_BITS (CAP_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job         (back_job),
		.pop         (pop),
		.lower_limit (lower_limit_q),
		.upper_limit (upper_limit_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_status  (res_status),
		.out_value   (res_value),
		.out_places  (res_places)
	);

	// Result packing, first field in the lowest bits.
	assign m_axis_tdata = {6'b0, res_places, res_value, res_status};

endmodule

`default_nettype wire

### rtl/dntp_checker.sv
// Port-level checks of the decimal text parser, bound to its top level.
// Depends on dntp_pkg for the status codes.
`default_nettype none

module dntp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [71:0] m_axis_tdata
);
	import dntp_pkg::*;

	// A stalled result transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result changed while stalled");

	// No result is offered while reset is applied.
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

	// Empty and malformed strings report a zero value.
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && ((m_axis_tdata[1:0] == ST_EMPTY) || (m_axis_tdata[1:0] == ST_END)))
		|-> (m_axis_tdata[62:2] == '0))
		else $error("nonzero value with empty or end expected status");

	// Padding above the places field stays zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[71:66] == '0))
		else $error("result padding bits set");

endmodule

bind decimal_number_text_parser dntp_checker u_dntp_checker (.*);

`default_nettype wire

### tb/sv/tb_decimal_number_text_parser.sv
`timescale 1ns / 1ps
// Self-checking testbench of decimal_number_text_parser: random text strings in,
// fixed-point results out, compared against an in-bench scanner and scaler.
// Depends on dntp_pkg and the parser RTL.

module tb_decimal_number_text_parser;
	import dntp_pkg::*;

	localparam int VALUE_BITS = 64;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_DIGIT_BUDGET   = 3'd0;
	localparam logic [2:0] REG_FRACTION_LIMIT = 3'd1;
	localparam logic [2:0] REG_TARGET_PLACES  = 3'd2;
	localparam logic [2:0] REG_LOWER_LIMIT    = 3'd3;
	localparam logic [2:0] REG_UPPER_LIMIT    = 3'd4;

	localparam longint LIM_MIN = -64'sd1152921504606846976;
	localparam longint LIM_MAX = 64'sd1152921504606846975;
	localparam longint BIG_TEN = 64'sd1000000000000000000;

	localparam int N_PHASES      = 8;
	localparam int CHARS_PER_SET = 180;
	localparam int DRAIN_CYCLES  = 150;
	localparam int HOLD_CYCLES   = 500;
	localparam int STALL_LIMIT   = 4000;

	typedef enum logic [2:0] {
		SCAN_START, SCAN_INT, SCAN_FRAC, SCAN_SUFFIX, SCAN_BAD
	} scan_phase_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [60:0] value;
		logic [2:0]  places;
	} number_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] ch
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;           // [1:0] status, [62:2] value, [65:63] places
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = 3'd0;
	logic [60:0] cfg_data = '0;

	decimal_number_text_parser #(.VALUE_BITS(VALUE_BITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the configuration registers, at their reset values.
	logic [3:0]         cf_budget = 4'd9;
	logic [3:0]         cf_frac = 4'd0;
	logic [2:0]         cf_places = 3'd0;
	logic signed [60:0] cf_lower = '0;
	logic signed [60:0] cf_upper = '0;

	// Scanner state of the string being received.
	scan_phase_t     sc_phase = SCAN_START;
	logic            sc_neg = 1'b0;
	longint unsigned sc_acc = 0;
	int              sc_int_cnt = 0;
	int              sc_frac_cnt = 0;

	logic [7:0]     char_queue[$];
	number_result_t expected_numbers[$];
	int             chars_queued = 0;
	int             chars_accepted = 0;
	int             results_seen = 0;
	int             mismatches = 0;
	logic           calm = 1'b0;

	int   send_gap;
	int   rx_stall;
	logic hold_done;
	int   idle_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mostly short idle gaps, a few long ones; none at all while calm is set.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic longint unsigned ten_to(input int k);
		longint unsigned p;
		p = 1;
		repeat (k) p = p * 10;
		return p;
	endfunction

	// Advance the scanner by one non-terminator character.
	function automatic void scan_char(input logic [7:0] c);
		logic digit_ch;
		int   room;
		int   allow;
		digit_ch = (c >= CH_ZERO) && (c <= CH_NINE);
		if (sc_phase == SCAN_START) begin
			if (c == CH_MINUS) begin
				sc_neg = 1'b1;
				sc_phase = SCAN_INT;
				return;
			end
			sc_phase = SCAN_INT;
		end
		case (sc_phase)
			SCAN_INT: begin
				if (digit_ch && sc_int_cnt < int'(cf_budget)) begin
					sc_acc = sc_acc * 10 + (c - CH_ZERO);
					sc_int_cnt++;
				end else if (c == CH_POINT && cf_frac != 0) begin
					sc_phase = SCAN_FRAC;
				end else if (c == CH_KILO) begin
					sc_acc = sc_acc * 1000;
					sc_phase = SCAN_SUFFIX;
				end else begin
					sc_phase = SCAN_BAD;
				end
			end
			SCAN_FRAC: begin
				room = (sc_int_cnt < int'(cf_budget)) ? int'(cf_budget) - sc_int_cnt : 0;
				allow = (room < int'(cf_frac)) ? room : int'(cf_frac);
				if (digit_ch && sc_frac_cnt < allow) begin
					sc_acc = sc_acc * 10 + (c - CH_ZERO);
					sc_frac_cnt++;
				end else if (c == CH_KILO) begin
					sc_acc = sc_acc * 1000;
					sc_phase = SCAN_SUFFIX;
				end else begin
					sc_phase = SCAN_BAD;
				end
			end
			default: sc_phase = SCAN_BAD;
		endcase
	endfunction

	// On a terminator: rescale, saturate, range check, then clear the scanner.
	function automatic number_result_t finish_number();
		number_result_t  r;
		longint unsigned cap;
		longint unsigned mag;
		longint unsigned p;
		longint          sval;
		longint          lo;
		longint          hi;
		logic            sat;
		int              tp;
		cap = (64'd1 << 60) - 1;
		if (VALUE_BITS < 61)
			cap = (64'd1 << (VALUE_BITS - 1)) - 1;
		r.status = ST_OK;
		r.value = '0;
		r.places = cf_places;
		if (sc_phase == SCAN_START) begin
			r.status = ST_EMPTY;
		end else if (sc_phase == SCAN_BAD) begin
			r.status = ST_END;
		end else begin
			mag = sc_acc;
			tp = int'(cf_places);
			sat = 1'b0;
			if (tp > sc_frac_cnt) begin
				p = ten_to(tp - sc_frac_cnt);
				if (mag > cap / p) begin
					mag = cap;
					sat = 1'b1;
				end else begin
					mag = mag * p;
				end
			end else if (sc_frac_cnt > tp) begin
				p = ten_to(sc_frac_cnt - tp);
				mag = (mag + p / 2) / p;
			end
			if (mag > cap) begin
				mag = cap;
				sat = 1'b1;
			end
			sval = sc_neg ? -longint'(mag) : longint'(mag);
			lo = cf_lower;
			hi = cf_upper;
			if (sat || sval < lo || sval > hi)
				r.status = ST_RANGE;
			r.value = sval[60:0];
		end
		sc_phase = SCAN_START;
		sc_neg = 1'b0;
		sc_acc = 0;
		sc_int_cnt = 0;
		sc_frac_cnt = 0;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
			field, results_seen, got, want);
		mismatches++;
	endtask

	// Sender: offers queued characters with random gaps between transactions.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'h00;
			send_gap <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (char_queue.size() != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= char_queue.pop_front();
				send_gap <= idle_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off once results are flowing.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_stall <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && results_seen >= 20) begin
			hold_done <= 1'b1;
			rx_stall <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			rx_stall <= ($urandom_range(0, 3) == 0) ? idle_gap() : 0;
		end
	end

	// Monitor: predicts on each accepted character and checks each result.
	always @(posedge clk) begin
		number_result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (expected_numbers.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata[63:0], '0);
				end else begin
					want = expected_numbers.pop_front();
					if (m_axis_tdata[1:0] != want.status)
						report_mismatch("status", 64'(m_axis_tdata[1:0]),
							64'(want.status));
					if (m_axis_tdata[62:2] != want.value)
						report_mismatch("value", 64'(m_axis_tdata[62:2]),
							64'(want.value));
					if (m_axis_tdata[65:63] != want.places)
						report_mismatch("places", 64'(m_axis_tdata[65:63]),
							64'(want.places));
					if (m_axis_tdata[71:66] != '0)
						report_mismatch("padding", 64'(m_axis_tdata[71:66]), '0);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				chars_accepted++;
				if (s_axis_tdata == CH_NUL)
					expected_numbers.push_back(finish_number());
				else
					scan_char(s_axis_tdata);
			end
		end
	end

	// Watchdog: ends the run when no transaction happens for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic push_char(input logic [7:0] c);
		char_queue.push_back(c);
		chars_queued++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
		push_char(CH_NUL);
	endtask

	task automatic push_digits(input int n);
		repeat (n) push_char(8'(CH_ZERO + $urandom_range(0, 9)));
	endtask

	// One string: mostly well-formed with random content, some noise or broken.
	task automatic queue_number_text();
		int kind;
		int n_int;
		int n_frac;
		int room;
		int allow;
		int junk_at;
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			repeat ($urandom_range(0, 6)) push_char(8'($urandom_range(1, 255)));
		end else begin
			junk_at = (kind < 24) ? $urandom_range(0, 3) : -1;
			if ($urandom_range(0, 1))
				push_char(CH_MINUS);
			if (junk_at == 0)
				push_char(8'($urandom_range(1, 255)));
			n_int = $urandom_range(0, 1) ? int'(cf_budget) : $urandom_range(0, cf_budget);
			if (kind >= 24 && kind < 30)
				n_int++;
			push_digits(n_int);
			if (junk_at == 1)
				push_char(8'($urandom_range(1, 255)));
			if (cf_frac != 0 && $urandom_range(0, 2) != 0) begin
				push_char(CH_POINT);
				room = (n_int < int'(cf_budget)) ? int'(cf_budget) - n_int : 0;
				allow = (room < int'(cf_frac)) ? room : int'(cf_frac);
				n_frac = $urandom_range(0, 1) ? allow : $urandom_range(0, allow);
				push_digits(n_frac);
			end
			if (junk_at == 2)
				push_char(8'($urandom_range(1, 255)));
			if ($urandom_range(0, 3) == 0)
				push_char(CH_KILO);
			if (junk_at == 3)
				push_char(8'($urandom_range(1, 255)));
		end
		push_char(CH_NUL);
	endtask

	task automatic queue_random(input int n);
		int stop_at;
		stop_at = chars_queued + n;
		while (chars_queued < stop_at)
			queue_number_text();
	endtask

	// Waits until every character is taken and every result has arrived.
	task automatic settle();
		while (chars_accepted != chars_queued || expected_numbers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input longint data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[60:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_settings(input int budget, input int frac, input int places,
			input longint lo, input longint hi);
		write_reg(REG_DIGIT_BUDGET, budget);
		write_reg(REG_FRACTION_LIMIT, frac);
		write_reg(REG_TARGET_PLACES, places);
		write_reg(REG_LOWER_LIMIT, lo);
		write_reg(REG_UPPER_LIMIT, hi);
		cf_budget = budget[3:0];
		cf_frac = frac[3:0];
		cf_places = places[2:0];
		cf_lower = lo[60:0];
		cf_upper = hi[60:0];
	endtask

	// Stimulus: reset values first, then a series of register settings.
	initial begin
		// Driven after every process waits on its clock or reset edge.
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		queue_random(60);
		settle();
		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: apply_settings(9, 3, 2, LIM_MIN, LIM_MAX);
				1: apply_settings(1, 0, 0, -5, 5);
				2: apply_settings(9, 9, 6, -BIG_TEN, BIG_TEN);
				3: apply_settings(15, 15, 7, LIM_MIN, LIM_MAX);
				4: apply_settings(0, 1, 3, 0, 0);
				5: apply_settings(4, 2, 0, -1000, 2500);
				default: apply_settings($urandom_range(1, 9), $urandom_range(0, 9),
					$urandom_range(0, 6), -longint'($urandom_range(0, 100000000)),
					longint'($urandom_range(0, 2000000000)));
			endcase
			calm = (ph % 3 == 1);
			if (ph == 0) begin
				// Empty string, lone sign, point and suffix, rounding, junk byte.
				push_text("");
				push_text("-");
				push_text(".");
				push_text("K");
				push_text("-9.99K");
				push_text("1.005");
				push_char("7");
				push_char(8'hFF);
				push_char(CH_NUL);
			end
			queue_random(CHARS_PER_SET);
			settle();
		end
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
